@@ hdl/spectral_bin_hold_damp_core_macros.svh @@
// assertion macros for the spectral bin hold and damp core
// used by files that assert; expects clk and rst_n in scope
`ifndef SPECTRAL_BIN_HOLD_DAMP_CORE_MACROS_SVH
`define SPECTRAL_BIN_HOLD_DAMP_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define SBHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SBHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbhd_pkg.sv @@
// shared types and constants for the spectral bin hold and damp core
// no dependencies
package sbhd_pkg;

    localparam int FFT_SIZE_DEFAULT = 1024;
    localparam int CFG_ADDR_W       = 4;
    localparam int CFG_DATA_W       = 32;
    localparam int AMP_W            = 32;
    localparam int FREQ_W           = 32;
    localparam int COUNT_W          = 20;
    localparam int DAMP_W           = 16;
    localparam int DAMP_FRAC        = 15;

    localparam logic [AMP_W-1:0]   THRESHOLD_RESET = 32'd168;
    localparam logic [DAMP_W-1:0]  DAMPING_RESET   = 16'd32440;
    localparam logic [COUNT_W-1:0] HOLD_RESET      = 20'd13781;

    typedef enum logic [1:0] {
        REG_RELOAD_THRESHOLD = 2'd0,
        REG_DAMPING          = 2'd1,
        REG_HOLD_FRAMES      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [AMP_W-1:0]   reload_threshold;
        logic [DAMP_W-1:0]  damping;
        logic [COUNT_W-1:0] hold_frames;
    } cfg_t;

    typedef struct packed {
        logic [AMP_W-1:0]         amplitude;
        logic signed [FREQ_W-1:0] frequency;
        logic                     last_bin;
    } bin_t;

    typedef struct packed {
        logic [AMP_W-1:0]         held_amplitude;
        logic signed [FREQ_W-1:0] held_frequency;
        logic                     frame_end;
    } result_t;

    typedef struct packed {
        logic [AMP_W-1:0]   amp;
        logic [FREQ_W-1:0]  freq;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

@@ hdl/sbhd_cfg_regs.sv @@
// apb configuration registers: reload threshold, damping, hold frames
// depends on sbhd_pkg
module sbhd_cfg_regs
    import sbhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reload_threshold <= THRESHOLD_RESET;
            cfg_reg.damping          <= DAMPING_RESET;
            cfg_reg.hold_frames      <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RELOAD_THRESHOLD: cfg_reg.reload_threshold <= pwdata;
                REG_DAMPING:          cfg_reg.damping          <= pwdata[DAMP_W-1:0];
                REG_HOLD_FRAMES:      cfg_reg.hold_frames      <= pwdata[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RELOAD_THRESHOLD: prdata = cfg_reg.reload_threshold;
            REG_DAMPING:          prdata = CFG_DATA_W'(cfg_reg.damping);
            REG_HOLD_FRAMES:      prdata = CFG_DATA_W'(cfg_reg.hold_frames);
            default:              prdata = '0;
        endcase
    end

endmodule

@@ hdl/spectral_bin_hold_damp_core.sv @@
// an accepted request is registered in stage one, then in the output register when it advances
// throughput: one request per cycle unless the result stalls; bin memory is read and written
//   back once per in-range request, forwarding a one-bin frame's repeated bin on the next cycle
// reset: clears position and pipeline valids and sets the first-frame flag; bin memory is not
//   cleared, the first frame after reset loads every bin
// top level; depends on sbhd_pkg, sbhd_cfg_regs and spectral_bin_hold_damp_core_macros.svh
`include "spectral_bin_hold_damp_core_macros.svh"

module spectral_bin_hold_damp_core
    import sbhd_pkg::*;
#(
    parameter int FFT_SIZE = FFT_SIZE_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  bin_t                  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_BINS = FFT_SIZE / 2 + 1;
    localparam int POS_W    = $clog2(NUM_BINS + 1);
    localparam int ADDR_W   = $clog2(NUM_BINS);

    cfg_t cfg;

    sbhd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // bin memory
    entry_t bin_mem [NUM_BINS];
    entry_t rd_entry_reg;

    // control state
    logic [POS_W-1:0]  bin_pos_reg, bin_pos_next;
    logic              first_frame_reg;
    logic              s1_valid_reg;
    logic              fwd_valid_reg;
    logic              result_valid_reg;

    // stage one and output payload
    bin_t              s1_item_reg;
    logic              s1_in_range_reg;
    logic              s1_first_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    entry_t            fwd_entry_reg;
    result_t           result_reg;

    logic              item_accept;
    logic              s1_adv;
    logic              pos_in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic              fwd_next;

    entry_t            cur_entry;
    entry_t            new_entry;
    logic [AMP_W-1:0]  amp_diff;
    logic              reload;
    logic [AMP_W+DAMP_W-1:0] damp_prod;
    logic [AMP_W:0]    damp_shift;
    logic [AMP_W-1:0]  damp_amp;
    result_t           result_next;

    assign item_accept  = item_valid & ~item_stall;
    assign s1_adv       = ~result_valid_reg | ~result_stall;
    assign item_stall   = s1_valid_reg & ~s1_adv;
    assign pos_in_range = bin_pos_reg < POS_W'(NUM_BINS);
    assign rd_addr      = bin_pos_reg[ADDR_W-1:0];
    assign mem_we       = s1_valid_reg & s1_in_range_reg & s1_adv;
    assign fwd_next     = item_accept & pos_in_range & mem_we & (s1_addr_reg == rd_addr);

    always_comb
    begin
        if (!pos_in_range)
            bin_pos_next = POS_W'(NUM_BINS);
        else
            bin_pos_next = bin_pos_reg + POS_W'(1);
        if (item.last_bin)
            bin_pos_next = '0;
    end

    // read-modify-write of the held entry
    always_comb
    begin
        cur_entry  = fwd_valid_reg ? fwd_entry_reg : rd_entry_reg;
        amp_diff   = (cur_entry.amp > s1_item_reg.amplitude)
                   ? cur_entry.amp - s1_item_reg.amplitude
                   : s1_item_reg.amplitude - cur_entry.amp;
        reload     = s1_first_reg | (amp_diff > cfg.reload_threshold)
                   | (cur_entry.count == '0);
        damp_prod  = (AMP_W+DAMP_W)'(cur_entry.amp) * (AMP_W+DAMP_W)'(cfg.damping);
        damp_shift = damp_prod[AMP_W+DAMP_FRAC:DAMP_FRAC];
        damp_amp   = damp_shift[AMP_W] ? '1 : damp_shift[AMP_W-1:0];

        if (reload)
        begin
            new_entry.amp   = s1_item_reg.amplitude;
            new_entry.freq  = s1_item_reg.frequency;
            new_entry.count = cfg.hold_frames;
        end
        else
        begin
            new_entry.amp   = damp_amp;
            new_entry.freq  = cur_entry.freq;
            new_entry.count = cur_entry.count - COUNT_W'(1);
        end

        if (s1_in_range_reg)
        begin
            result_next.held_amplitude = new_entry.amp;
            result_next.held_frequency = new_entry.freq;
        end
        else
        begin
            result_next.held_amplitude = s1_item_reg.amplitude;
            result_next.held_frequency = s1_item_reg.frequency;
        end
        result_next.frame_end = s1_item_reg.last_bin;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[s1_addr_reg] <= new_entry;
        if (item_accept && pos_in_range)
            rd_entry_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_pos_reg      <= '0;
            first_frame_reg  <= 1'b1;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                bin_pos_reg <= bin_pos_next;
                if (item.last_bin)
                    first_frame_reg <= 1'b0;
            end

            if (item_accept)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= fwd_next;
            end
            else if (s1_adv)
            begin
                s1_valid_reg  <= 1'b0;
                fwd_valid_reg <= 1'b0;
            end

            if (s1_adv)
                result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg     <= item;
            s1_in_range_reg <= pos_in_range;
            s1_first_reg    <= first_frame_reg;
            s1_addr_reg     <= rd_addr;
        end
        if (fwd_next)
            fwd_entry_reg <= new_entry;
        if (s1_adv && s1_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SBHD_ASSERT_NOW(a_pos_bounded, 1'b1, bin_pos_reg <= POS_W'(NUM_BINS), "position overrun")
    `SBHD_ASSERT_NEXT(a_last_clears_pos, item_accept && item.last_bin, bin_pos_reg == '0, "pos kept")
    `SBHD_ASSERT_NOW(a_fwd_needs_item, fwd_valid_reg, s1_valid_reg && s1_in_range_reg, "stray fwd")
    `SBHD_ASSERT_NOW(a_first_never_rises, 1'b1, !$rose(first_frame_reg), "first-frame flag set")

endmodule
